>>> hw/rtl/dow_jg_pkg.sv
// ----------------------------------------------------------------------------
// dow_jg_pkg
// Shared types, calendar constants and month tables for the weekday pipeline.
// ----------------------------------------------------------------------------
package dow_jg_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int WDAY_W  = 3;
    localparam int DSUM_W  = 9;
    localparam int PROD_W  = 27;
    localparam int CENT_W  = 8;
    localparam int TOTAL_W = 15;

    localparam logic [YEAR_W-1:0]  SWITCH_YEAR  = 14'd1752;
    localparam logic [YEAR_W-1:0]  MAX_YEAR     = 14'd9999;
    localparam logic [DSUM_W-1:0]  SKIPPED_DAYS = 9'd11;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0]   GAP_FIRST = 5'd3;
    localparam logic [DAY_W-1:0]   GAP_LAST  = 5'd13;
    localparam logic [DAY_W-1:0]   LEAP_FEB_LEN = 5'd29;

    // floor(m / 100) == (m * 5243) >> 19 for every 14-bit m
    localparam logic [12:0]        RECIP_100   = 13'd5243;
    localparam int                 RECIP_SHIFT = 19;
    localparam logic [YEAR_W-1:0]  HUNDRED     = 14'd100;
    localparam logic [6:0]         CENT_END    = 7'd99;

    localparam logic [CENT_W-1:0]  GREG_BIAS   = 8'd9;
    localparam logic [TOTAL_W-1:0] WEEK_BASE   = 15'd5;
    localparam logic [WDAY_W-1:0]  WDAY_NONE   = 3'd0;
    localparam logic [WDAY_W-1:0]  WDAY_SAT    = 3'd7;

    // Stage 1 -> stage 2
    typedef struct packed {
        logic                range_ok;
        logic                sep_gap;
        logic                greg;
        logic                is_feb;
        logic                after_feb;
        logic [DAY_W-1:0]    day;
        logic [DAY_W-1:0]    len_base;
        logic [YEAR_W-1:0]   year;
        logic [YEAR_W-1:0]   yprev;
        logic [PROD_W-1:0]   prod;
        logic [DSUM_W-1:0]   dsum;
    } t_s1;

    // Stage 2 -> stage 3
    typedef struct packed {
        logic                date_ok;
        logic [TOTAL_W-1:0]  total;
    } t_s2;

    function automatic logic [DSUM_W-1:0] f_days_before(input logic [MONTH_W-1:0] month);
        logic [DSUM_W-1:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] l;
        case (month)
            4'd2:    l = 5'd28;
            4'd4:    l = 5'd30;
            4'd6:    l = 5'd30;
            4'd9:    l = 5'd30;
            4'd11:   l = 5'd30;
            default: l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

>>> hw/rtl/dow_jg_decode.sv
// ----------------------------------------------------------------------------
// dow_jg_decode
// Stage 1: range checks, 1752 switch handling, day-of-year prefix and the
// reciprocal product for the century count.
// ----------------------------------------------------------------------------
module dow_jg_decode (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [dow_jg_pkg::DAY_W-1:0]   i_day_of_month,
    input  logic [dow_jg_pkg::MONTH_W-1:0] i_month_number,
    input  logic [dow_jg_pkg::YEAR_W-1:0]  i_year_number,
    output logic                           o_valid,
    output dow_jg_pkg::t_s1                o_data
);

    logic                          r_valid;
    dow_jg_pkg::t_s1               r_data;
    dow_jg_pkg::t_s1               n_data;
    logic                          is_switch_year;
    logic                          sub_skip;
    logic [dow_jg_pkg::YEAR_W-1:0] yprev;

    always_comb begin
        is_switch_year = (i_year_number == dow_jg_pkg::SWITCH_YEAR);
        // Sep 14 onward in 1752 is pulled back by the skipped days
        sub_skip = is_switch_year &&
                   (((i_month_number == dow_jg_pkg::MONTH_SEP) &&
                     (i_day_of_month > dow_jg_pkg::GAP_LAST)) ||
                    (i_month_number > dow_jg_pkg::MONTH_SEP));
        yprev = i_year_number - 14'd1;

        n_data.range_ok  = (i_year_number != '0) &&
                           (i_year_number <= dow_jg_pkg::MAX_YEAR) &&
                           (i_month_number >= dow_jg_pkg::MONTH_JAN) &&
                           (i_month_number <= dow_jg_pkg::MONTH_DEC);
        n_data.sep_gap   = is_switch_year &&
                           (i_month_number == dow_jg_pkg::MONTH_SEP) &&
                           (i_day_of_month >= dow_jg_pkg::GAP_FIRST) &&
                           (i_day_of_month <= dow_jg_pkg::GAP_LAST);
        n_data.greg      = (i_year_number > dow_jg_pkg::SWITCH_YEAR);
        n_data.is_feb    = (i_month_number == dow_jg_pkg::MONTH_FEB);
        n_data.after_feb = (i_month_number > dow_jg_pkg::MONTH_FEB);
        n_data.day       = i_day_of_month;
        n_data.len_base  = dow_jg_pkg::f_month_len(i_month_number);
        n_data.year      = i_year_number;
        n_data.yprev     = yprev;
        n_data.prod      = dow_jg_pkg::PROD_W'(yprev) *
                           dow_jg_pkg::PROD_W'(dow_jg_pkg::RECIP_100);
        n_data.dsum      = dow_jg_pkg::f_days_before(i_month_number) +
                           dow_jg_pkg::DSUM_W'(i_day_of_month) -
                           (sub_skip ? dow_jg_pkg::SKIPPED_DAYS : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/dow_jg_count.sv
// ----------------------------------------------------------------------------
// dow_jg_count
// Stage 2: century count, leap rule, day validity and the raw day total.
// ----------------------------------------------------------------------------
module dow_jg_count (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  dow_jg_pkg::t_s1 i_data,
    output logic            o_valid,
    output dow_jg_pkg::t_s2 o_data
);

    logic                           r_valid;
    dow_jg_pkg::t_s2                r_data;
    dow_jg_pkg::t_s2                n_data;
    logic [dow_jg_pkg::CENT_W-1:0]  cent;
    logic [dow_jg_pkg::CENT_W-1:0]  cent_next;
    logic [dow_jg_pkg::YEAR_W-1:0]  rem_full;
    logic [6:0]                     rem100;
    logic                           leap;
    logic [dow_jg_pkg::DAY_W-1:0]   len;
    logic [dow_jg_pkg::CENT_W-1:0]  corr;

    always_comb begin
        // cent = (year-1)/100, rem100 = (year-1)%100
        cent      = dow_jg_pkg::CENT_W'(i_data.prod >> dow_jg_pkg::RECIP_SHIFT);
        cent_next = cent + 8'd1;
        rem_full  = i_data.yprev - dow_jg_pkg::YEAR_W'(cent) * dow_jg_pkg::HUNDRED;
        rem100    = rem_full[6:0];
        // year%100==0 <=> (year-1)%100==99; then year/100 == cent+1
        leap      = (i_data.year[1:0] == 2'b00) &&
                    (!i_data.greg || (rem100 != dow_jg_pkg::CENT_END) ||
                     (cent_next[1:0] == 2'b00));
        len       = (i_data.is_feb && leap) ? dow_jg_pkg::LEAP_FEB_LEN : i_data.len_base;
        // Gregorian drop: c - c/4 - 9, c = (year-1)/100
        corr      = i_data.greg ? (cent - (cent >> 2) - dow_jg_pkg::GREG_BIAS) : '0;

        n_data.date_ok = i_data.range_ok && !i_data.sep_gap &&
                         (i_data.day != '0) && (i_data.day <= len);
        n_data.total   = dow_jg_pkg::TOTAL_W'(i_data.year) + dow_jg_pkg::WEEK_BASE +
                         dow_jg_pkg::TOTAL_W'(i_data.yprev >> 2) -
                         dow_jg_pkg::TOTAL_W'(corr) +
                         dow_jg_pkg::TOTAL_W'(i_data.dsum) +
                         dow_jg_pkg::TOTAL_W'(leap && i_data.after_feb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/dow_jg_mod7.sv
// ----------------------------------------------------------------------------
// dow_jg_mod7
// Stage 3: day total mod 7 by octal digit folding; output register.
// ----------------------------------------------------------------------------
module dow_jg_mod7 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  dow_jg_pkg::t_s2               i_data,
    output logic                          o_valid,
    output logic [dow_jg_pkg::WDAY_W-1:0] o_weekday
);

    logic                          r_valid;
    logic [dow_jg_pkg::WDAY_W-1:0] r_weekday;
    logic [dow_jg_pkg::WDAY_W-1:0] n_weekday;
    logic [5:0]                    fold1;
    logic [3:0]                    fold2;
    logic [3:0]                    rem7;

    always_comb begin
        // 8 == 1 mod 7: sum the octal digits twice, then one correction
        fold1 = 6'(i_data.total[2:0]) + 6'(i_data.total[5:3]) + 6'(i_data.total[8:6]) +
                6'(i_data.total[11:9]) + 6'(i_data.total[14:12]);
        fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
        rem7  = (fold2 >= 4'd7) ? (fold2 - 4'd7) : fold2;
        if (!i_data.date_ok) begin
            n_weekday = dow_jg_pkg::WDAY_NONE;
        end else if (rem7 == 4'd0) begin
            n_weekday = dow_jg_pkg::WDAY_SAT;
        end else begin
            n_weekday = rem7[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_weekday <= n_weekday;
        end
    end

    assign o_valid   = r_valid;
    assign o_weekday = r_weekday;

endmodule

>>> hw/rtl/day_of_week_julian_gregorian.sv
// ----------------------------------------------------------------------------
// day_of_week_julian_gregorian
// Weekday of a date (1 Sunday .. 7 Saturday, 0 for an invalid date), Julian
// leap rule through 1752, Gregorian after, with the September 1752 gap.
// ----------------------------------------------------------------------------
//
//  channel   direction   handshake              payload
//  --------  ---------   --------------------   -------------------------------
//  date in   input       i_valid / o_stall      i_day_of_month, i_month_number,
//                                               i_year_number
//  weekday   output      o_valid / i_stall      o_weekday
//
//  o_valid rises once an accepted request has passed all three register
//  stages; with no stall the result is taken while o_valid is high.
//  One request per cycle is taken when nothing stalls (no loops).
//  Reset (i_rst_n low, synchronous) clears only the stage valid bits.
//  A stall on the output holds the result; each stage still fills while it
//  holds a bubble, so o_stall rises only when all three stages are full.
//
// Stage 1: range checks, 1752 gap, day-of-year prefix, (year-1)*recip(100).
// Stage 2: century count and remainder, leap rule, month length, day total.
// Stage 3: total mod 7 mapped to 1..7, registered as the output.
// ----------------------------------------------------------------------------
module day_of_week_julian_gregorian (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [dow_jg_pkg::DAY_W-1:0]   i_day_of_month,
    input  logic [dow_jg_pkg::MONTH_W-1:0] i_month_number,
    input  logic [dow_jg_pkg::YEAR_W-1:0]  i_year_number,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [dow_jg_pkg::WDAY_W-1:0]  o_weekday
);

    logic            s1_valid;
    logic            s2_valid;
    dow_jg_pkg::t_s1 s1_data;
    dow_jg_pkg::t_s2 s2_data;
    logic            adv1;
    logic            adv2;
    logic            adv3;

    // A stage loads when it is empty or its content moves on this cycle.
    assign adv3    = !o_valid  || !i_stall;
    assign adv2    = !s2_valid || adv3;
    assign adv1    = !s1_valid || adv2;
    assign o_stall = !adv1;

    dow_jg_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv1),
        .i_valid        (i_valid),
        .i_day_of_month (i_day_of_month),
        .i_month_number (i_month_number),
        .i_year_number  (i_year_number),
        .o_valid        (s1_valid),
        .o_data         (s1_data)
    );

    dow_jg_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv2),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .o_data  (s2_data)
    );

    dow_jg_mod7 u_mod7 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv3),
        .i_valid   (s2_valid),
        .i_data    (s2_data),
        .o_valid   (o_valid),
        .o_weekday (o_weekday)
    );

`ifndef NO_ASSERTIONS
    // Back-pressure reaches the input only with the whole pipe full and stalled.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && s1_valid && s2_valid && i_stall))
        else $error("input stalled while the pipeline has room");

    // With a free output, an accepted request reaches o_valid through the decode, count and mod7 stages.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("accepted request did not reach the output");

    // Reset empties the pipe.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !s1_valid && !s2_valid))
        else $error("valid bits survived reset");
`endif

endmodule
